### hw/rtl/dsf_pkg.sv
// Shared types and constants for the damped spring force pipeline.
package dsf_pkg;

    // Fixed point format and datapath widths.
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int REST_W     = 31;
    localparam int MIN_SEP_W  = 16;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int U_W        = FRAC_BITS + 2;
    localparam int LANES      = 3;

    // Clamp bound for the integer part of the scalar force magnitude.
    localparam logic signed [36:0] SH_MAX = 37'sh0_4_0000_0000;
    localparam logic signed [36:0] SH_MIN = -37'sh0_4_0000_0000;

    // Output range bounds.
    localparam logic signed [54:0] OUT_MAX = 55'sh0_7FFF_FFFF;
    localparam logic signed [54:0] OUT_MIN = -55'sh0_8000_0000;

    // One input word: one spring joint.
    typedef struct packed {
        logic signed [DATA_W-1:0] delta_pos_x;
        logic signed [DATA_W-1:0] delta_pos_y;
        logic signed [DATA_W-1:0] delta_pos_z;
        logic signed [DATA_W-1:0] delta_vel_x;
        logic signed [DATA_W-1:0] delta_vel_y;
        logic signed [DATA_W-1:0] delta_vel_z;
        logic        [REST_W-1:0] rest_length;
        logic signed [DATA_W-1:0] stiffness;
        logic signed [DATA_W-1:0] damping;
    } t_dsf_in;

    // One output word: force on the first body.
    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     skipped;
        logic                     saturated;
    } t_dsf_out;

    // Joint data carried alongside the divider.
    typedef struct packed {
        t_dsf_in             item;
        logic [ROOT_W-1:0]   sep;
        logic                skip;
    } t_dsf_side;

endpackage

### hw/rtl/damped_spring_force.sv
// An accepted word passes the square and sum registers, the square root, the
// divider and the force stages. Throughput: one word per cycle; the 32-stage
// square root and the 17-stage divider are fully pipelined, and the whole
// pipeline advances whenever the output register is empty or being read.
// Reset: synchronous, active low; clears all valid bits and sets the
// minimum separation to 1.
module damped_spring_force (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dsf_pkg::t_dsf_in              i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dsf_pkg::t_dsf_out             o_out_word,
    input  logic                          i_cfg_we,
    input  logic [dsf_pkg::MIN_SEP_W-1:0] i_cfg_wdata
);
    import dsf_pkg::*;

    logic                 w_en;
    logic [DATA_W-1:0]    n_mag [LANES];
    logic [SQ_W-1:0]      n_sq  [LANES];

    logic [MIN_SEP_W-1:0] r_min_sep;

    logic                 r_a_valid;
    logic [SQ_W-1:0]      r_a_sq [LANES];
    t_dsf_in              r_a_item;

    logic                 r_b_valid;
    logic [SQ_W-1:0]      r_b_sum;
    t_dsf_in              r_b_item;

    logic                 w_sq_valid;
    t_dsf_in              w_sq_item;
    logic [ROOT_W-1:0]    w_root;
    t_dsf_side            w_side;

    logic                 w_dv_valid;
    t_dsf_side            w_dv_side;
    logic signed [U_W-1:0] w_u [LANES];

    // The pipeline moves when the output register is free or being read.
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sep <= MIN_SEP_W'(1);
        end else if (i_cfg_we) begin
            r_min_sep <= i_cfg_wdata;
        end
    end

    // Squared magnitudes of the displacement.
    always_comb begin
        n_mag[0] = i_in_word.delta_pos_x[DATA_W-1] ? (DATA_W'(0) - i_in_word.delta_pos_x)
                                                   : i_in_word.delta_pos_x;
        n_mag[1] = i_in_word.delta_pos_y[DATA_W-1] ? (DATA_W'(0) - i_in_word.delta_pos_y)
                                                   : i_in_word.delta_pos_y;
        n_mag[2] = i_in_word.delta_pos_z[DATA_W-1] ? (DATA_W'(0) - i_in_word.delta_pos_z)
                                                   : i_in_word.delta_pos_z;
        for (int l = 0; l < LANES; l++) begin
            n_sq[l] = SQ_W'(n_mag[l]) * SQ_W'(n_mag[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // Square stage, then the sum of squares.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sq   <= n_sq;
            r_a_item <= i_in_word;
            r_b_sum  <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_b_item <= r_a_item;
        end
    end

    dsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_valid),
        .i_item  (r_b_item),
        .i_rad   (r_b_sum),
        .o_valid (w_sq_valid),
        .o_item  (w_sq_item),
        .o_root  (w_root)
    );

    // Skip test: zero separation or below the threshold.
    always_comb begin
        w_side.item = w_sq_item;
        w_side.sep  = w_root;
        w_side.skip = (w_root == '0) || (w_root < ROOT_W'(r_min_sep));
    end

    dsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_side  (w_side),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_u     (w_u)
    );

    dsf_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_valid),
        .i_side  (w_dv_side),
        .i_u     (w_u),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

### hw/rtl/dsf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module dsf_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  dsf_pkg::t_dsf_in         i_item,
    input  logic [dsf_pkg::SQ_W-1:0] i_rad,
    output logic                     o_valid,
    output dsf_pkg::t_dsf_in         o_item,
    output logic [dsf_pkg::ROOT_W-1:0] o_root
);
    import dsf_pkg::*;

    logic [35:0]       r_rem   [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root  [SQRT_STEPS];
    logic [SQ_W-1:0]   r_x     [SQRT_STEPS];
    t_dsf_in           r_item  [SQRT_STEPS];
    logic              r_valid [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        logic [35:0]       s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SQ_W-1:0]   s_x;
        t_dsf_in           s_item;
        logic              s_valid;
        logic [35:0]       n_cat;
        logic [35:0]       n_trial;
        logic              n_ge;

        // Stage source: the radicand for the first stage, the previous stage otherwise.
        if (g == 0) begin : g_first
            always_comb begin
                s_rem   = '0;
                s_root  = '0;
                s_x     = i_rad;
                s_item  = i_item;
                s_valid = i_valid;
            end
        end else begin : g_next
            always_comb begin
                s_rem   = r_rem[g-1];
                s_root  = r_root[g-1];
                s_x     = r_x[g-1];
                s_item  = r_item[g-1];
                s_valid = r_valid[g-1];
            end
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            n_cat   = {s_rem[33:0], s_x[SQ_W-1:SQ_W-2]};
            n_trial = {2'b00, s_root, 2'b01};
            n_ge    = (n_cat >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_ge ? (n_cat - n_trial) : n_cat;
                r_root[g] <= {s_root[ROOT_W-2:0], n_ge};
                r_x[g]    <= {s_x[SQ_W-3:0], 2'b00};
                r_item[g] <= s_item;
            end
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_item  = r_item[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];

endmodule

### hw/rtl/dsf_div.sv
// Pipelined three-lane restoring divider that forms the unit axis.
module dsf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  dsf_pkg::t_dsf_side i_side,
    output logic               o_valid,
    output dsf_pkg::t_dsf_side o_side,
    output logic signed [dsf_pkg::U_W-1:0] o_u [dsf_pkg::LANES]
);
    import dsf_pkg::*;

    logic [DATA_W-1:0] w_mag [LANES];
    logic              w_neg [LANES];

    logic [DATA_W-1:0] r_rem   [DIV_STEPS][LANES];
    logic [QUO_W-1:0]  r_q     [DIV_STEPS][LANES];
    logic              r_neg   [DIV_STEPS][LANES];
    t_dsf_side         r_side  [DIV_STEPS];
    logic              r_valid [DIV_STEPS];

    // Split each displacement into sign and magnitude.
    always_comb begin
        w_neg[0] = i_side.item.delta_pos_x[DATA_W-1];
        w_neg[1] = i_side.item.delta_pos_y[DATA_W-1];
        w_neg[2] = i_side.item.delta_pos_z[DATA_W-1];
        w_mag[0] = w_neg[0] ? (DATA_W'(0) - i_side.item.delta_pos_x) : i_side.item.delta_pos_x;
        w_mag[1] = w_neg[1] ? (DATA_W'(0) - i_side.item.delta_pos_y) : i_side.item.delta_pos_y;
        w_mag[2] = w_neg[2] ? (DATA_W'(0) - i_side.item.delta_pos_z) : i_side.item.delta_pos_z;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [DATA_W-1:0] s_rem [LANES];
        logic [QUO_W-1:0]  s_q   [LANES];
        logic              s_neg [LANES];
        logic              s_bit [LANES];
        t_dsf_side         s_side;
        logic              s_valid;

        // Stage source: the magnitude's upper bits first, then the running remainder.
        if (g == 0) begin : g_first
            always_comb begin
                s_side  = i_side;
                s_valid = i_valid;
                for (int l = 0; l < LANES; l++) begin
                    s_rem[l] = {1'b0, w_mag[l][DATA_W-1:1]};
                    s_q[l]   = '0;
                    s_neg[l] = w_neg[l];
                    s_bit[l] = w_mag[l][0];
                end
            end
        end else begin : g_next
            always_comb begin
                s_side  = r_side[g-1];
                s_valid = r_valid[g-1];
                for (int l = 0; l < LANES; l++) begin
                    s_rem[l] = r_rem[g-1][l];
                    s_q[l]   = r_q[g-1][l];
                    s_neg[l] = r_neg[g-1][l];
                    s_bit[l] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= s_valid;
            end
        end

        // One quotient bit per lane: subtract the separation where it fits.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DATA_W:0] n_cat;
            logic [DATA_W:0] n_div;
            logic            n_ge;

            always_comb begin
                n_cat = {s_rem[l], s_bit[l]};
                n_div = {1'b0, s_side.sep};
                n_ge  = (n_cat >= n_div);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g][l] <= n_ge ? DATA_W'(n_cat - n_div) : n_cat[DATA_W-1:0];
                    r_q[g][l]   <= {s_q[l][QUO_W-2:0], n_ge};
                    r_neg[g][l] <= s_neg[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= s_side;
            end
        end
    end

    // Restore the sign: truncation toward zero.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_u[l] = r_neg[DIV_STEPS-1][l] ? -$signed({1'b0, r_q[DIV_STEPS-1][l]})
                                           :  $signed({1'b0, r_q[DIV_STEPS-1][l]});
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

### hw/rtl/dsf_force.sv
// Force pipeline: axial velocity, spring and damper terms, scaling and clamping.
module dsf_force (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  dsf_pkg::t_dsf_side i_side,
    input  logic signed [dsf_pkg::U_W-1:0] i_u [dsf_pkg::LANES],
    output logic               o_valid,
    output dsf_pkg::t_dsf_out  o_word
);
    import dsf_pkg::*;

    logic signed [DATA_W-1:0] w_v [LANES];

    // Stage 1 registers.
    logic                     r1_valid;
    logic signed [49:0]       r1_p [LANES];
    logic signed [33:0]       r1_e;
    logic signed [U_W-1:0]    r1_u [LANES];
    logic signed [DATA_W-1:0] r1_k;
    logic signed [DATA_W-1:0] r1_c;
    logic                     r1_skip;

    // Stage 2 registers.
    logic                     r2_valid;
    logic signed [35:0]       r2_va;
    logic signed [33:0]       r2_e;
    logic signed [U_W-1:0]    r2_u [LANES];
    logic signed [DATA_W-1:0] r2_k;
    logic signed [DATA_W-1:0] r2_c;
    logic                     r2_skip;

    // Stage 3 registers.
    logic                     r3_valid;
    logic signed [65:0]       r3_ke;
    logic signed [67:0]       r3_cva;
    logic signed [U_W-1:0]    r3_u [LANES];
    logic                     r3_skip;

    // Stage 4 registers.
    logic                     r4_valid;
    logic signed [35:0]       r4_shc;
    logic [FRAC_BITS-1:0]     r4_sl;
    logic signed [U_W-1:0]    r4_u [LANES];
    logic                     r4_skip;

    // Stage 5 registers.
    logic                     r5_valid;
    logic signed [53:0]       r5_a [LANES];
    logic signed [34:0]       r5_b [LANES];
    logic                     r5_skip;

    // Output register.
    logic                     r6_valid;
    t_dsf_out                 r6_word;

    logic signed [49:0]       n_p [LANES];
    logic signed [33:0]       n_e;
    logic signed [51:0]       n_sum;
    logic signed [52:0]       n_g;
    logic signed [36:0]       n_sh;
    logic signed [54:0]       n_r [LANES];
    logic signed [DATA_W-1:0] n_f [LANES];
    logic [LANES-1:0]         n_sat;

    assign w_v[0] = i_side.item.delta_vel_x;
    assign w_v[1] = i_side.item.delta_vel_y;
    assign w_v[2] = i_side.item.delta_vel_z;

    // Velocity times axis per lane, and the extension.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_p[l] = w_v[l] * i_u[l];
        end
        n_e = $signed({2'b00, i_side.sep}) - $signed({3'b000, i_side.item.rest_length});
    end

    // Axial velocity, floored to the fixed point grid.
    always_comb begin
        n_sum = 52'(r1_p[0]) + 52'(r1_p[1]) + 52'(r1_p[2]);
    end

    // Scalar force, with its integer part clamped.
    always_comb begin
        n_g  = 53'(r3_ke >>> FRAC_BITS) + 53'(r3_cva >>> FRAC_BITS);
        n_sh = 37'(n_g >>> FRAC_BITS);
        if (n_sh > SH_MAX) begin
            n_sh = SH_MAX;
        end else if (n_sh < SH_MIN) begin
            n_sh = SH_MIN;
        end
    end

    // Recombine the partial products and clamp to the output range.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_r[l] = 55'(r5_a[l]) + 55'(r5_b[l] >>> FRAC_BITS);
            if (n_r[l] > OUT_MAX) begin
                n_f[l]   = OUT_MAX[DATA_W-1:0];
                n_sat[l] = 1'b1;
            end else if (n_r[l] < OUT_MIN) begin
                n_f[l]   = OUT_MIN[DATA_W-1:0];
                n_sat[l] = 1'b1;
            end else begin
                n_f[l]   = n_r[l][DATA_W-1:0];
                n_sat[l] = 1'b0;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n_p;
            r1_e    <= n_e;
            r1_u    <= i_u;
            r1_k    <= i_side.item.stiffness;
            r1_c    <= i_side.item.damping;
            r1_skip <= i_side.skip;

            r2_va   <= 36'(n_sum >>> FRAC_BITS);
            r2_e    <= r1_e;
            r2_u    <= r1_u;
            r2_k    <= r1_k;
            r2_c    <= r1_c;
            r2_skip <= r1_skip;

            r3_ke   <= r2_k * r2_e;
            r3_cva  <= r2_c * r2_va;
            r3_u    <= r2_u;
            r3_skip <= r2_skip;

            r4_shc  <= n_sh[35:0];
            r4_sl   <= n_g[FRAC_BITS-1:0];
            r4_u    <= r3_u;
            r4_skip <= r3_skip;

            for (int l = 0; l < LANES; l++) begin
                r5_a[l] <= r4_u[l] * r4_shc;
                r5_b[l] <= r4_u[l] * $signed({1'b0, r4_sl});
            end
            r5_skip <= r4_skip;

            if (r5_skip) begin
                r6_word <= '{force_x: '0, force_y: '0, force_z: '0,
                             skipped: 1'b1, saturated: 1'b0};
            end else begin
                r6_word <= '{force_x: n_f[0], force_y: n_f[1], force_z: n_f[2],
                             skipped: 1'b0, saturated: |n_sat};
            end
        end
    end

    assign o_valid = r6_valid;
    assign o_word  = r6_word;

endmodule

### hw/rtl/dsf_checker.sv
// Port-level assertions for the damped spring force block, with its bind.
module dsf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input dsf_pkg::t_dsf_in              i_in_word,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input dsf_pkg::t_dsf_out             o_out_word,
    input logic                          i_cfg_we,
    input logic [dsf_pkg::MIN_SEP_W-1:0] i_cfg_wdata
);
    import dsf_pkg::*;

    localparam logic signed [DATA_W-1:0] F_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] F_MIN = 32'sh8000_0000;

    // A waiting result word stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // A stalled output stalls the input.
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // A skipped joint carries no force and no saturation.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.skipped |->
            o_out_word.force_x == '0 && o_out_word.force_y == '0 &&
            o_out_word.force_z == '0 && !o_out_word.saturated)
        else $error("skipped joint with nonzero force");

    // Saturation shows a component at a range bound.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.saturated |->
            o_out_word.force_x == F_MAX || o_out_word.force_x == F_MIN ||
            o_out_word.force_y == F_MAX || o_out_word.force_y == F_MIN ||
            o_out_word.force_z == F_MAX || o_out_word.force_z == F_MIN)
        else $error("saturation flag without a clamped component");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (.*);
